/* rtl/lzss_window_decoder_macros.svh */
// assertion macros for the lzss window decoder
`ifndef LZSS_WINDOW_DECODER_MACROS_SVH
`define LZSS_WINDOW_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define LZSSWD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define LZSSWD_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LZSSWD_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define LZSSWD_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

/* rtl/lzsswd_pkg.sv */
// shared types and constants of the lzss window decoder
package lzsswd_pkg;

    localparam int WIN_AW = 12;
    localparam int LIMIT_W = 24;
    localparam logic [WIN_AW-1:0] START_POS = 12'd4080;
    localparam logic [4:0] MIN_MATCH = 5'd3;
    localparam logic [3:0] FLAGS_PER_BYTE = 4'd8;
    localparam logic [1:0] FIFO_FULL = 2'd2;
    localparam logic STAT_DONE = 1'b0;
    localparam logic STAT_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COPY,
        ST_END
    } dec_state_t;

    typedef enum logic {
        KIND_DATA = 1'b0,
        KIND_END  = 1'b1
    } res_kind_t;

    typedef struct packed {
        logic              we;
        logic [WIN_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [WIN_AW-1:0] raddr;
    } win_req_t;

    typedef struct packed {
        res_kind_t  kind;
        logic [7:0] data;
        logic       run_last;
        logic       status;
    } res_item_t;

    typedef struct packed {
        logic      valid;
        res_item_t item;
    } res_push_t;

endpackage

/* rtl/lzsswd_window_ram.sv */
// 4096 x 8 history window, one write and one registered read port
module lzsswd_window_ram
    import lzsswd_pkg::*;
(
    input  logic       aclk,
    input  win_req_t   req,
    output logic [7:0] rd_data
);

    logic [7:0] mem [2**WIN_AW];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // write-first: a copy may read the byte written in the same cycle
    always_ff @(posedge aclk) begin
        if (req.re) begin
            if (req.we && (req.waddr == req.raddr)) begin
                rd_data_reg <= req.wdata;
            end else begin
                rd_data_reg <= mem[req.raddr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/lzsswd_result_fifo.sv */
// two-entry result queue in front of the output channel
module lzsswd_result_fifo
    import lzsswd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  res_push_t   push,
    input  logic        pop,
    output res_item_t   head,
    output logic        head_valid,
    output logic [1:0]  count
);

    res_item_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push.valid;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push.valid} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            slot_reg[wr_ptr_reg] <= push.item;
        end
    end

    assign head       = slot_reg[rd_ptr_reg];
    assign head_valid = (count_reg != 2'd0);
    assign count      = count_reg;

endmodule

/* rtl/lzsswd_token_ctrl.sv */
// token parser and match copy sequencer around the window memory
module lzsswd_token_ctrl
    import lzsswd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic [7:0]         s_byte,
    input  logic               s_last,
    output logic               s_ready,
    input  logic [LIMIT_W-1:0] limit,
    input  logic [1:0]         fifo_count,
    input  logic               pop,
    input  logic [7:0]         rd_data,
    output win_req_t           mem_req,
    output res_push_t          push,
    output logic               clearing
);

    dec_state_t         state_reg, state_next;
    logic [WIN_AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [WIN_AW-1:0]  wp_reg, wp_next;
    logic [7:0]         flag_bits_reg, flag_bits_next;
    logic [3:0]         flags_left_reg, flags_left_next;
    logic               awaiting_reg, awaiting_next;
    logic [7:0]         match_low_reg, match_low_next;
    logic [LIMIT_W-1:0] produced_reg, produced_next;
    logic               stopped_reg, stopped_next;
    logic               last_pend_reg, last_pend_next;
    logic [WIN_AW-1:0]  src_reg, src_next;
    logic [4:0]         remain_reg, remain_next;
    logic               rdv_reg, rdv_next;

    logic              space_now;
    logic [2:0]        occ;
    logic              accept;
    logic              stop_now;
    logic [WIN_AW-1:0] match_dist;
    logic [4:0]        mlen;
    logic [WIN_AW-1:0] msrc;
    logic              fits;
    logic              tok_flag;
    logic              tok_high;
    logic              tok_low;
    logic              start_copy;
    logic              lit;
    logic              issue;
    logic              copy_done;

    always_comb begin
        space_now  = (fifo_count != FIFO_FULL) || pop;
        // queue fill counted with the read data in flight, so a read issued now always finds room
        occ        = {1'b0, fifo_count} + {2'b0, rdv_reg} - {2'b0, pop};
        accept     = s_valid && s_ready;
        stop_now   = stopped_reg || (produced_reg >= limit);
        match_dist = {s_byte[3:0], match_low_reg};
        mlen       = {1'b0, s_byte[7:4]} + MIN_MATCH;
        msrc       = wp_reg - match_dist - 12'd1;
        fits       = ({1'b0, produced_reg} + {20'd0, mlen}) <= {1'b0, limit};
        tok_flag   = (flags_left_reg == 4'd0);
        tok_high   = !tok_flag && awaiting_reg;
        tok_low    = !tok_flag && !awaiting_reg && flag_bits_reg[0];
        start_copy = accept && !stop_now && tok_high && fits;
        lit        = accept && !stop_now && !tok_flag && !awaiting_reg && !flag_bits_reg[0];
        issue      = (state_reg == ST_COPY) && (remain_reg != 5'd0) && (occ <= 3'd1);
        copy_done  = (state_reg == ST_COPY) && (remain_reg == 5'd0) && rdv_reg;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start_copy) begin
                    state_next = ST_COPY;
                end else if (accept && s_last) begin
                    state_next = ST_END;
                end
            end
            ST_COPY: begin
                if (copy_done) begin
                    state_next = last_pend_reg ? ST_END : ST_IDLE;
                end
            end
            ST_END: begin
                if (space_now) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // outputs
    always_comb begin
        s_ready  = 1'b0;
        clearing = 1'b0;
        mem_req  = '0;
        push     = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                clearing      = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_cnt_reg;
                mem_req.wdata = 8'd0;
            end
            ST_IDLE: begin
                s_ready = space_now;
                if (lit) begin
                    mem_req.we         = 1'b1;
                    mem_req.waddr      = wp_reg;
                    mem_req.wdata      = s_byte;
                    push.valid         = 1'b1;
                    push.item.kind     = KIND_DATA;
                    push.item.data     = s_byte;
                    push.item.run_last = !s_last;
                    push.item.status   = STAT_DONE;
                end
            end
            ST_COPY: begin
                mem_req.re    = issue;
                mem_req.raddr = src_reg;
                if (rdv_reg) begin
                    mem_req.we         = 1'b1;
                    mem_req.waddr      = wp_reg;
                    mem_req.wdata      = rd_data;
                    push.valid         = 1'b1;
                    push.item.kind     = KIND_DATA;
                    push.item.data     = rd_data;
                    push.item.run_last = copy_done && !last_pend_reg;
                    push.item.status   = STAT_DONE;
                end
            end
            ST_END: begin
                push.valid         = space_now;
                push.item.kind     = KIND_END;
                push.item.data     = 8'd0;
                push.item.run_last = 1'b1;
                push.item.status   = stopped_reg ? STAT_LIMIT : STAT_DONE;
            end
        endcase
    end

    // datapath state
    always_comb begin
        clr_cnt_next    = clr_cnt_reg;
        wp_next         = wp_reg;
        flag_bits_next  = flag_bits_reg;
        flags_left_next = flags_left_reg;
        awaiting_next   = awaiting_reg;
        match_low_next  = match_low_reg;
        produced_next   = produced_reg;
        stopped_next    = stopped_reg;
        last_pend_next  = last_pend_reg;
        src_next        = src_reg;
        remain_next     = remain_reg;
        rdv_next        = issue;

        if (state_reg == ST_CLEAR) begin
            clr_cnt_next = clr_cnt_reg + 12'd1;
        end

        if (accept) begin
            last_pend_next = s_last;
            if (stop_now) begin
                stopped_next = 1'b1;
            end else if (tok_flag) begin
                flag_bits_next  = s_byte;
                flags_left_next = FLAGS_PER_BYTE;
            end else if (tok_high) begin
                awaiting_next   = 1'b0;
                flag_bits_next  = {1'b0, flag_bits_reg[7:1]};
                flags_left_next = flags_left_reg - 4'd1;
                if (fits) begin
                    src_next    = msrc;
                    remain_next = mlen;
                end else begin
                    stopped_next = 1'b1;
                end
            end else if (tok_low) begin
                match_low_next = s_byte;
                awaiting_next  = 1'b1;
            end else begin
                flag_bits_next  = {1'b0, flag_bits_reg[7:1]};
                flags_left_next = flags_left_reg - 4'd1;
                wp_next         = wp_reg + 12'd1;
                produced_next   = produced_reg + 24'd1;
            end
        end

        if (issue) begin
            src_next    = src_reg + 12'd1;
            remain_next = remain_reg - 5'd1;
        end
        if ((state_reg == ST_COPY) && rdv_reg) begin
            wp_next       = wp_reg + 12'd1;
            produced_next = produced_reg + 24'd1;
        end

        // end status delivered: back to the start of a stream
        if ((state_reg == ST_END) && space_now) begin
            wp_next         = START_POS;
            flag_bits_next  = 8'd0;
            flags_left_next = 4'd0;
            awaiting_next   = 1'b0;
            match_low_next  = 8'd0;
            produced_next   = '0;
            stopped_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            wp_reg         <= START_POS;
            flag_bits_reg  <= 8'd0;
            flags_left_reg <= 4'd0;
            awaiting_reg   <= 1'b0;
            match_low_reg  <= 8'd0;
            produced_reg   <= '0;
            stopped_reg    <= 1'b0;
            last_pend_reg  <= 1'b0;
            remain_reg     <= 5'd0;
            rdv_reg        <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            wp_reg         <= wp_next;
            flag_bits_reg  <= flag_bits_next;
            flags_left_reg <= flags_left_next;
            awaiting_reg   <= awaiting_next;
            match_low_reg  <= match_low_next;
            produced_reg   <= produced_next;
            stopped_reg    <= stopped_next;
            last_pend_reg  <= last_pend_next;
            remain_reg     <= remain_next;
            rdv_reg        <= rdv_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg <= src_next;
    end

endmodule

/* rtl/lzss_window_decoder.sv */
// Flag, literal and low match bytes are accepted while the result queue has room; a literal's
// item is ready the next cycle. A high match byte starts a copy: the window read port issues
// one copy read a cycle while the queue has room, and each byte is written back and queued in
// the cycle after its read, so 1 byte per cycle. An item with in_last is followed by an end
// status item. After reset a clearing pass zeroes the 4096-byte window, one entry a cycle,
// and no item is accepted until it finishes; output_limit resets to 16777215.
`include "lzss_window_decoder_macros.svh"

module lzss_window_decoder
    import lzsswd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // compressed input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] in_byte
    input  logic        s_tlast,  // in_last
    // decompressed output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // [7:0] out_byte, [8] status, [15:9] zero
    output logic        m_tlast,  // run_last
    output logic        m_tuser   // kind
);

    logic [LIMIT_W-1:0] limit_reg;
    logic               cfg_write;
    logic               m_pop;
    logic [1:0]         fifo_count;
    logic [7:0]         rd_data;
    logic               clearing;
    win_req_t           mem_req;
    res_push_t          push;
    res_item_t          head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= 24'hFFFFFF;
        end else if (cfg_write) begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {8'd0, limit_reg};

    lzsswd_token_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_byte     (s_tdata),
        .s_last     (s_tlast),
        .s_ready    (s_tready),
        .limit      (limit_reg),
        .fifo_count (fifo_count),
        .pop        (m_pop),
        .rd_data    (rd_data),
        .mem_req    (mem_req),
        .push       (push),
        .clearing   (clearing)
    );

    lzsswd_window_ram u_window (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    lzsswd_result_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .pop        (m_pop),
        .head       (head),
        .head_valid (m_tvalid),
        .count      (fifo_count)
    );

    assign m_pop   = m_tvalid && m_tready;
    assign m_tdata = {7'd0, head.status, head.data};
    assign m_tlast = head.run_last;
    assign m_tuser = head.kind;

    `LZSSWD_ASSERT_IMP(a_push_has_room, aclk, aresetn, push.valid && (fifo_count == FIFO_FULL), m_pop, "result pushed into a full queue")
    `LZSSWD_ASSERT_IMP(a_no_accept_in_clear, aclk, aresetn, s_tvalid && s_tready, !clearing, "item accepted during window clear")
    `LZSSWD_ASSERT_NXT(a_copy_read_lands, aclk, aresetn, mem_req.re, push.valid && (push.item.kind == KIND_DATA), "copy read not queued next cycle")

endmodule

/* test/testbench.sv */
// self-checking testbench for the lzss window decoder
module testbench;
    import lzsswd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_OUTPUT_LIMIT = 3'd0;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 30;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } comp_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] in_byte
    logic        s_tlast;   // in_last
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] out_byte, [8] status, [15:9] zero
    logic        m_tlast;   // run_last
    logic        m_tuser;   // kind

    lzss_window_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    comp_byte_t pending_q[$];
    res_item_t  decoded_q[$];
    int         send_idle_pct;
    int         recv_idle_pct;
    int         recv_hold;
    int         err_count;
    int         stall_cycles;
    bit         in_taken;

    // decoder model state
    logic [7:0]  win_mem [4096];
    logic [11:0] wr_ptr;
    logic [7:0]  flag_reg;
    logic [3:0]  flag_cnt;
    logic        mid_match;
    logic [7:0]  match_lo;
    int unsigned out_count;
    int unsigned byte_cap;
    logic        halted;

    function automatic void restart_stream();
        wr_ptr = START_POS;
        flag_reg = '0;
        flag_cnt = '0;
        mid_match = 1'b0;
        match_lo = '0;
        out_count = 0;
        halted = 1'b0;
    endfunction

    function automatic void put_data(input logic [7:0] b);
        res_item_t r;
        win_mem[wr_ptr] = b;
        wr_ptr = wr_ptr + 12'd1;
        out_count = out_count + 1;
        r.kind = KIND_DATA;
        r.data = b;
        r.run_last = 1'b0;
        r.status = STAT_DONE;
        decoded_q.push_back(r);
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic last);
        res_item_t   r;
        int unsigned len;
        int          produced_now;
        logic [11:0] src;
        produced_now = 0;
        if (!halted && out_count >= byte_cap)
            halted = 1'b1;
        if (!halted) begin
            if (flag_cnt == 0) begin
                flag_reg = b;
                flag_cnt = FLAGS_PER_BYTE;
            end else if (mid_match) begin
                len = b[7:4] + MIN_MATCH;
                src = wr_ptr - {b[3:0], match_lo} - 12'd1;
                mid_match = 1'b0;
                flag_reg = flag_reg >> 1;
                flag_cnt = flag_cnt - 4'd1;
                if (out_count + len > byte_cap) begin
                    halted = 1'b1;
                end else begin
                    // byte by byte so an overlapping copy sees its own output
                    repeat (len) begin
                        put_data(win_mem[src]);
                        src = src + 12'd1;
                    end
                    produced_now = len;
                end
            end else if (flag_reg[0]) begin
                match_lo = b;
                mid_match = 1'b1;
            end else begin
                flag_reg = flag_reg >> 1;
                flag_cnt = flag_cnt - 4'd1;
                put_data(b);
                produced_now = 1;
            end
        end
        if (last) begin
            r.kind = KIND_END;
            r.data = '0;
            r.run_last = 1'b0;
            r.status = halted ? STAT_LIMIT : STAT_DONE;
            decoded_q.push_back(r);
            produced_now++;
            restart_stream();
        end
        if (produced_now > 0)
            decoded_q[$].run_last = 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTED)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // input side: predict on every accepted item
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            decode_byte(s_tdata, s_tlast);
            in_taken = 1'b1;
        end
    end

    always @(negedge aclk) begin : feed
        comp_byte_t nxt;
        if (!s_tvalid || in_taken) begin
            in_taken = 1'b0;
            if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = pending_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= nxt.data;
                s_tlast <= nxt.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (recv_hold > 0) begin
            recv_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        res_item_t got;
        res_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = res_kind_t'(m_tuser);
            got.data = m_tdata[7:0];
            got.run_last = m_tlast;
            got.status = m_tdata[8];
            if (decoded_q.size() == 0) begin
                report_mismatch($sformatf("unexpected item kind %0d byte %02h last %0b status %0b",
                    got.kind, got.data, got.run_last, got.status));
            end else begin
                want = decoded_q.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        "got kind %0d byte %02h last %0b status %0b, want %0d %02h %0b %0b",
                        got.kind, got.data, got.run_last, got.status,
                        want.kind, want.data, want.run_last, want.status));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic void add_byte(input logic [7:0] b, input logic last);
        pending_q.push_back(comp_byte_t'{data: b, last: last});
    endfunction

    // one compressed stream, mostly well formed, with a few broken endings
    function automatic int queue_stream();
        comp_byte_t  sq[$];
        logic [7:0]  flags;
        logic [11:0] back_dist;
        int          tokens;
        int          ending;
        int          k;
        bit          was_match;
        ending = $urandom_range(0, 9);
        tokens = (ending == 1) ? 8 * $urandom_range(1, 3) : $urandom_range(1, 24);
        was_match = 1'b0;
        flags = '0;
        if (ending == 3) begin
            repeat ($urandom_range(1, 20))
                sq.push_back(comp_byte_t'{data: 8'($urandom), last: 1'b0});
        end else begin
            for (k = 0; k < tokens; k++) begin
                if (k % 8 == 0) begin
                    flags = 8'($urandom);
                    sq.push_back(comp_byte_t'{data: flags, last: 1'b0});
                end
                was_match = flags[k % 8];
                if (was_match) begin
                    // short distances give overlapping repeats
                    back_dist = $urandom_range(0, 1) ? 12'($urandom_range(0, 40))
                                                     : 12'($urandom);
                    sq.push_back(comp_byte_t'{data: back_dist[7:0], last: 1'b0});
                    sq.push_back(comp_byte_t'{data: {4'($urandom), back_dist[11:8]},
                                              last: 1'b0});
                end else begin
                    sq.push_back(comp_byte_t'{data: 8'($urandom), last: 1'b0});
                end
            end
            if (ending == 0 && was_match)
                void'(sq.pop_back());
            if (ending == 1)
                sq.push_back(comp_byte_t'{data: 8'($urandom), last: 1'b0});
            if (ending == 2)
                sq[$urandom_range(0, sq.size() - 1)].data = 8'($urandom);
        end
        sq[$].last = 1'b1;
        foreach (sq[i])
            pending_q.push_back(sq[i]);
        return sq.size();
    endfunction

    task automatic write_limit(input logic [23:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_OUTPUT_LIMIT;
        pwdata <= {8'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        byte_cap = value;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        do
            @(posedge aclk);
        while (pending_q.size() != 0 || s_tvalid || decoded_q.size() != 0);
        // bytes that produce nothing may still be in flight
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic random_phase(input int send_pct, input int recv_pct,
                                input logic [23:0] cap, input int hold);
        int added;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_limit(cap);
        added = 0;
        while (added < 128)
            added += queue_stream();
        recv_hold = hold;
        drain();
    endtask

    initial begin
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        recv_hold = 0;
        err_count = 0;
        stall_cycles = 0;
        in_taken = 1'b0;
        send_idle_pct = 15;
        recv_idle_pct = 75;
        foreach (win_mem[i])
            win_mem[i] = '0;
        byte_cap = 24'hFFFFFF;
        restart_stream();

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // literals, overlapping match, farthest match, half match at the end
        add_byte(8'hFA, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h12, 1'b1);
        // a lone flag byte as a whole stream
        add_byte(8'h7F, 1'b1);
        drain();

        // limit of one: second token stops the stream
        write_limit(24'd1);
        add_byte(8'h02, 1'b0);
        add_byte(8'h33, 1'b0);
        add_byte(8'h44, 1'b0);
        add_byte(8'h55, 1'b1);
        drain();

        // match longer than what the limit leaves
        write_limit(24'd4);
        add_byte(8'h01, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h20, 1'b0);
        add_byte(8'h66, 1'b1);
        drain();

        write_limit(24'd0);
        add_byte(8'hA5, 1'b0);
        add_byte(8'h5A, 1'b1);
        drain();

        // limit lowered below the bytes already produced, mid stream
        write_limit(24'hFFFFFF);
        add_byte(8'h00, 1'b0);
        add_byte(8'h11, 1'b0);
        add_byte(8'h22, 1'b0);
        add_byte(8'h33, 1'b0);
        drain();
        write_limit(24'd2);
        add_byte(8'h44, 1'b0);
        add_byte(8'h55, 1'b1);
        drain();

        random_phase(15, 75, 24'hFFFFFF, 300);
        random_phase(75, 15, 24'($urandom_range(40, 400)), 0);
        random_phase(0, 0, 24'($urandom_range(400, 16777214)), 0);

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/lzsswd_pkg.sv
rtl/lzsswd_window_ram.sv
rtl/lzsswd_result_fifo.sv
rtl/lzsswd_token_ctrl.sv
rtl/lzss_window_decoder.sv
test/testbench.sv
